/* rtl/core/multicore_job_dispatcher_unit_macros.svh */
// Assertion macros for the multicore job dispatcher.
// Included by modules that carry concurrent checks; depends on clk_i and rst_ni in scope.
`ifndef MULTICORE_JOB_DISPATCHER_UNIT_MACROS_SVH
`define MULTICORE_JOB_DISPATCHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MJD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mjd check failed");
`define MJD_ASSERT_NEVER(lbl, cond) \
  `MJD_ASSERT(lbl, !(cond))
`else
`define MJD_ASSERT(lbl, prop)
`define MJD_ASSERT_NEVER(lbl, cond)
`endif

`endif

/* rtl/core/mjd_pkg.sv */
// Shared constants, codes and types of the multicore job dispatcher.
// Used by mjd_cell, mjd_queue and multicore_job_dispatcher_unit; no dependencies.
package mjd_pkg;

  localparam int QueueDepth = 64;
  localparam int MaxCores   = 8;
  localparam int CoreIdxW   = $clog2(MaxCores);
  localparam int NumCoresW  = 4;
  localparam int JobW       = 16;
  localparam int KeyW       = 32;

  localparam logic [1:0] CMD_NEW     = 2'd0;
  localparam logic [1:0] CMD_FINISH  = 2'd1;
  localparam logic [1:0] CMD_QUANTUM = 2'd2;

  localparam logic [1:0] SCH_ARRIVAL = 2'd0;
  localparam logic [1:0] SCH_RUNLEN  = 2'd1;
  localparam logic [1:0] SCH_PRIO    = 2'd2;
  localparam logic [1:0] SCH_RR      = 2'd3;

  localparam logic REG_SCHEME    = 1'b0;
  localparam logic REG_NUM_CORES = 1'b1;

  typedef enum logic [1:0] {
    QOP_NONE,
    QOP_INSERT,
    QOP_POP
  } qop_e;

  typedef struct packed {
    logic            valid;
    logic [JobW-1:0] job;
    logic [KeyW-1:0] key;
  } entry_t;

  typedef struct packed {
    qop_e            op;
    logic            at_back;
    logic [JobW-1:0] job;
    logic [KeyW-1:0] key;
  } qreq_t;

endpackage

/* rtl/core/mjd_cell.sv */
// One slot of the sorted wait queue: holds an entry and trades it with its neighbors.
// Depends on mjd_pkg.
module mjd_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mjd_pkg::qreq_t req_i,
  input  mjd_pkg::entry_t prev_i,
  input  logic           g_prev_i,
  input  mjd_pkg::entry_t next_i,
  output mjd_pkg::entry_t ent_o,
  output logic           g_o
);

  mjd_pkg::entry_t ent_q, ent_d;

  // The new word goes at or before this slot once any slot up to here is empty or holds a
  // larger key.
  assign g_o = g_prev_i || !ent_q.valid || (!req_i.at_back && (ent_q.key > req_i.key));

  always_comb begin
    ent_d = ent_q;
    case (req_i.op)
      mjd_pkg::QOP_INSERT: begin
        if (g_o) begin
          if (g_prev_i) begin
            ent_d = prev_i;
          end else begin
            ent_d.valid = 1'b1;
            ent_d.job   = req_i.job;
            ent_d.key   = req_i.key;
          end
        end
      end
      mjd_pkg::QOP_POP: begin
        ent_d = next_i;
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

/* rtl/core/mjd_queue.sv */
// Sorted wait queue built as a row of mjd_cell slots, head at slot zero.
// Depends on mjd_pkg and mjd_cell.
module mjd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mjd_pkg::qreq_t  req_i,
  output mjd_pkg::entry_t head_o,
  output logic            full_o
);

  localparam int Last = mjd_pkg::QueueDepth - 1;

  mjd_pkg::entry_t ent [mjd_pkg::QueueDepth];
  logic            g   [mjd_pkg::QueueDepth];

  for (genvar i = 0; i < mjd_pkg::QueueDepth; i++) begin : g_cell
    mjd_pkg::entry_t prev, nxt;
    logic            g_prev;

    if (i == 0) begin : g_first
      assign prev   = '0;
      assign g_prev = 1'b0;
    end else begin : g_mid
      assign prev   = ent[i-1];
      assign g_prev = g[i-1];
    end

    if (i == Last) begin : g_end
      assign nxt = '0;
    end else begin : g_inner
      assign nxt = ent[i+1];
    end

    mjd_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .req_i    (req_i),
      .prev_i   (prev),
      .g_prev_i (g_prev),
      .next_i   (nxt),
      .ent_o    (ent[i]),
      .g_o      (g[i])
    );
  end

  assign head_o = ent[0];
  assign full_o = ent[Last].valid;

endmodule

/* rtl/core/multicore_job_dispatcher_unit.sv */
// Top level of the multicore job dispatcher: core table, event sequencer, result register.
// Depends on mjd_pkg, mjd_queue and multicore_job_dispatcher_unit_macros.svh.
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   command, job_id, core_index, submit_time, ...
//   out      out_valid_o / out_ready_i dispatched, target_core, next_job, queue_full
//   cfg      cfg_we_i                  cfg_index_i, cfg_data_i
//
// An event word is captured in S_IDLE, then decided in S_EXEC, which also shifts the cell row.
// A round robin requeue of a running job adds the S_REQ state for the append into the row.
// Execution waits while the result register still holds an untaken word.
// Reset clears the queue valid flags and core busy flags at once; there is no clearing pass.
`include "multicore_job_dispatcher_unit_macros.svh"

module multicore_job_dispatcher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] job_id_i,
  input  logic [2:0]  core_index_i,
  input  logic [31:0] submit_time_i,
  input  logic [15:0] run_length_i,
  input  logic [15:0] priority_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        dispatched_o,
  output logic [2:0]  target_core_o,
  output logic [15:0] next_job_o,
  output logic        queue_full_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_REQ  = 2'd2;

  localparam int JobW = mjd_pkg::JobW;
  localparam int KeyW = mjd_pkg::KeyW;
  localparam int CiW  = mjd_pkg::CoreIdxW;
  localparam int NcW  = mjd_pkg::NumCoresW;

  logic [1:0]     state_q, state_d;
  logic [1:0]     scheme_q;
  logic [NcW-1:0] num_cores_q;

  logic [1:0]      cmd_q;
  logic [JobW-1:0] job_q;
  logic [2:0]      core_q;
  logic [KeyW-1:0] key_q, key_in;

  logic            busy_q [mjd_pkg::MaxCores];
  logic            busy_d [mjd_pkg::MaxCores];
  logic [JobW-1:0] cjob_q [mjd_pkg::MaxCores];
  logic [JobW-1:0] cjob_d [mjd_pkg::MaxCores];

  logic [JobW-1:0] req_job_q, req_job_d;

  logic            out_valid_q, out_valid_d;
  logic            disp_q, disp_d;
  logic [2:0]      tcore_q, tcore_d;
  logic [JobW-1:0] next_q, next_d;
  logic            full_q, full_d;

  mjd_pkg::qreq_t  qreq;
  mjd_pkg::entry_t head;
  logic            q_full;

  logic            accept, commit, core_ok, free_found, requeue;
  logic [NcW-1:0]  ncores;
  logic [CiW-1:0]  free_idx;

  mjd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (qreq),
    .head_o (head),
    .full_o (q_full)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    case (scheme_q)
      mjd_pkg::SCH_ARRIVAL: key_in = submit_time_i;
      mjd_pkg::SCH_RUNLEN:  key_in = {16'd0, run_length_i};
      mjd_pkg::SCH_PRIO:    key_in = {16'd0, priority_req_i};
      default:              key_in = '0;
    endcase
  end

  assign ncores  = (num_cores_q > NcW'(mjd_pkg::MaxCores)) ? NcW'(mjd_pkg::MaxCores)
                                                           : num_cores_q;
  assign core_ok = ({1'b0, core_q} < ncores);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int c = mjd_pkg::MaxCores - 1; c >= 0; c--) begin
      if ((c < int'(ncores)) && !busy_q[c]) begin
        free_found = 1'b1;
        free_idx   = CiW'(c);
      end
    end
  end

  always_comb begin
    busy_d    = busy_q;
    cjob_d    = cjob_q;
    state_d   = state_q;
    req_job_d = req_job_q;
    requeue   = 1'b0;
    disp_d    = 1'b0;
    tcore_d   = '0;
    next_d    = '0;
    full_d    = 1'b0;
    qreq      = '{op: mjd_pkg::QOP_NONE, at_back: 1'b0, job: '0, key: '0};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q)
          mjd_pkg::CMD_NEW: begin
            if (free_found) begin
              busy_d[free_idx] = 1'b1;
              cjob_d[free_idx] = job_q;
              disp_d           = 1'b1;
              tcore_d          = 3'(free_idx);
            end else if (q_full) begin
              full_d = 1'b1;
            end else begin
              qreq.op      = mjd_pkg::QOP_INSERT;
              qreq.at_back = (scheme_q == mjd_pkg::SCH_RR);
              qreq.job     = job_q;
              qreq.key     = (scheme_q == mjd_pkg::SCH_RR) ? '0 : key_q;
            end
          end
          mjd_pkg::CMD_FINISH: begin
            if (core_ok) begin
              tcore_d = core_q;
              if (head.valid) begin
                qreq.op        = mjd_pkg::QOP_POP;
                busy_d[core_q] = 1'b1;
                cjob_d[core_q] = head.job;
                disp_d         = 1'b1;
                next_d         = head.job;
              end else begin
                busy_d[core_q] = 1'b0;
                cjob_d[core_q] = '0;
              end
            end
          end
          mjd_pkg::CMD_QUANTUM: begin
            if (core_ok) begin
              tcore_d = core_q;
              if ((scheme_q == mjd_pkg::SCH_RR) && head.valid) begin
                qreq.op        = mjd_pkg::QOP_POP;
                busy_d[core_q] = 1'b1;
                cjob_d[core_q] = head.job;
                disp_d         = 1'b1;
                next_d         = head.job;
                requeue        = busy_q[core_q];
                req_job_d      = cjob_q[core_q];
              end else begin
                next_d = busy_q[core_q] ? cjob_q[core_q] : '0;
              end
            end
          end
          default: begin
            disp_d = 1'b0;
          end
        endcase
        if (!commit) begin
          busy_d    = busy_q;
          cjob_d    = cjob_q;
          req_job_d = req_job_q;
          requeue   = 1'b0;
          qreq.op   = mjd_pkg::QOP_NONE;
        end else begin
          state_d = requeue ? S_REQ : S_IDLE;
        end
      end
      S_REQ: begin
        qreq.op      = mjd_pkg::QOP_INSERT;
        qreq.at_back = 1'b1;
        qreq.job     = req_job_q;
        qreq.key     = '0;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scheme_q    <= mjd_pkg::SCH_ARRIVAL;
      num_cores_q <= NcW'(1);
      out_valid_q <= 1'b0;
      for (int c = 0; c < mjd_pkg::MaxCores; c++) begin
        busy_q[c] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      if (cfg_we_i) begin
        if (cfg_index_i == mjd_pkg::REG_SCHEME) begin
          scheme_q <= cfg_data_i[1:0];
        end else begin
          num_cores_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cjob_q    <= cjob_d;
    req_job_q <= req_job_d;
    if (accept) begin
      cmd_q  <= command_i;
      job_q  <= job_id_i;
      core_q <= core_index_i;
      key_q  <= key_in;
    end
    if (commit) begin
      disp_q  <= disp_d;
      tcore_q <= tcore_d;
      next_q  <= next_d;
      full_q  <= full_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dispatched_o  = disp_q;
  assign target_core_o = tcore_q;
  assign next_job_o    = next_q;
  assign queue_full_o  = full_q;

  `MJD_ASSERT(a_pop_needs_head, (qreq.op == mjd_pkg::QOP_POP) |-> head.valid)
  `MJD_ASSERT_NEVER(a_insert_into_full, (qreq.op == mjd_pkg::QOP_INSERT) && q_full)
  `MJD_ASSERT(a_requeue_after_exec, (state_q == S_REQ) |-> ($past(state_q) == S_EXEC))
  `MJD_ASSERT(a_dispatch_marks_busy, (commit && disp_d) |=> busy_q[tcore_q])

endmodule
